/* rtl/core/ctd_pkg.sv */
`timescale 1ns / 1ps

package ctd_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int TEXT_DEPTH  = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W  = $clog2(TEXT_DEPTH);
    localparam int LEN_W   = $clog2(TEXT_DEPTH + 1);
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int KC_W    = $clog2(MAX_COLUMNS + 1);
    localparam int PROD_W  = LEN_W + KC_W;
    localparam int CHAR_W  = 8;
    localparam int KL_W    = 5;
    localparam int ORDER_W = 63;
    localparam int ENTRY_W = 4;
    localparam int ENTRIES = 16;
    localparam int CFG_W   = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_ORDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_VERTICAL = 2'd2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_op_kind;

    typedef struct packed {
        logic [KL_W-1:0]    key_length;
        logic [ORDER_W-1:0] column_order;
        logic               read_vertical;
    } t_cfg;

    // one queued buffer access, in program order
    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
        logic              rd_en;
        logic              last;
        logic              ovf;
        logic              bad;
    } t_op;

endpackage

/* rtl/core/ctd_ram.sv */
`timescale 1ns / 1ps

module ctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ctd_front.sv */
`timescale 1ns / 1ps

module ctd_front import ctd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_in_last,
    input  t_cfg              i_cfg,
    output logic              o_push,
    output t_op               o_op
);

    typedef struct packed {
        t_op_kind           kind;
        logic [ADDR_W-1:0]  waddr;
        logic [CHAR_W-1:0]  data;
        logic [LEN_W-1:0]   row;
        logic [ENTRY_W-1:0] entry;
        logic [LEN_W-1:0]   rows;
        logic [KC_W-1:0]    kc;
        logic [LEN_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
        logic               vert;
        logic               ovf;
        logic               bad;
        logic               last;
    } t_snap;

    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] data;
        logic [PROD_W-1:0] limit;
        logic [PROD_W-1:0] base;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic              ovf;
        logic              bad;
        logic              last;
    } t_calc;

    function automatic logic [ENTRY_W-1:0] key_entry(input logic [ORDER_W-1:0] order,
                                                     input logic [ENTRY_W-1:0] idx);
        logic [ENTRIES*ENTRY_W-1:0] wide;
        wide = {{(ENTRIES*ENTRY_W-ORDER_W){1'b0}}, order};
        return wide[idx*ENTRY_W +: ENTRY_W];
    endfunction

    // pairwise form: every check is independent of the others
    function automatic logic key_bad(input logic [KL_W-1:0] kl,
                                     input logic [ORDER_W-1:0] order);
        logic bad;
        bad = (kl == '0) || (kl > KL_W'(MAX_COLUMNS)) || (kl > KL_W'(ENTRIES));
        for (int j = 0; j < ENTRIES; j++) begin
            if (KL_W'(j) < kl) begin
                if (KL_W'(key_entry(order, ENTRY_W'(j))) >= kl) begin
                    bad = 1'b1;
                end
                for (int k = j + 1; k < ENTRIES; k++) begin
                    if (KL_W'(k) < kl &&
                        key_entry(order, ENTRY_W'(j)) == key_entry(order, ENTRY_W'(k))) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        return bad;
    endfunction

    logic [LEN_W-1:0] r_text_len, n_text_len;
    logic [LEN_W-1:0] r_full_rows, n_full_rows;
    logic [COL_W-1:0] r_load_col, n_load_col;
    logic             r_loaded, n_loaded;
    logic             r_ovf, n_ovf;
    logic [LEN_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [LEN_W-1:0] r_out_pos, n_out_pos;

    logic  r_s1_valid, n_s1_valid;
    t_snap r_s1, n_s1;
    logic  r_s2_valid;
    t_calc r_s2, n_s2;

    logic [KC_W-1:0] kc;

    always_comb begin
        if (i_cfg.key_length == '0) begin
            kc = KC_W'(1);
        end else if (i_cfg.key_length > KL_W'(MAX_COLUMNS)) begin
            kc = KC_W'(MAX_COLUMNS);
        end else begin
            kc = KC_W'(i_cfg.key_length);
        end
    end

    always_comb begin
        n_text_len  = r_text_len;
        n_full_rows = r_full_rows;
        n_load_col  = r_load_col;
        n_loaded    = r_loaded;
        n_ovf       = r_ovf;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_pos   = r_out_pos;
        n_s1_valid  = 1'b0;
        n_s1        = '0;
        if (i_accept) begin
            if (i_req_type == OP_LOAD) begin
                // a new text after a completed one starts from scratch
                if (r_loaded) begin
                    n_text_len  = '0;
                    n_full_rows = '0;
                    n_load_col  = '0;
                    n_loaded    = 1'b0;
                    n_ovf       = 1'b0;
                    n_out_row   = '0;
                    n_out_col   = '0;
                    n_out_pos   = '0;
                end
                if (n_text_len < LEN_W'(TEXT_DEPTH)) begin
                    n_s1_valid = 1'b1;
                    n_s1.kind  = OP_LOAD;
                    n_s1.waddr = n_text_len[ADDR_W-1:0];
                    n_s1.data  = i_in_char;
                    n_text_len = n_text_len + LEN_W'(1);
                    if (KC_W'(n_load_col) + KC_W'(1) >= kc) begin
                        n_load_col  = '0;
                        n_full_rows = n_full_rows + LEN_W'(1);
                    end else begin
                        n_load_col = n_load_col + COL_W'(1);
                    end
                end else begin
                    n_ovf = 1'b1;
                end
                if (i_in_last) begin
                    n_loaded = 1'b1;
                end
            end else if (r_loaded) begin
                if (r_text_len == '0) begin
                    n_loaded  = 1'b0;
                    n_ovf     = 1'b0;
                    n_full_rows = '0;
                    n_load_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                    n_out_pos = '0;
                end else begin
                    n_s1_valid = 1'b1;
                    n_s1.kind  = OP_FETCH;
                    n_s1.row   = r_out_row;
                    n_s1.entry = key_entry(i_cfg.column_order, ENTRY_W'(r_out_col));
                    n_s1.rows  = r_full_rows;
                    n_s1.kc    = kc;
                    n_s1.pos   = r_out_pos;
                    n_s1.len   = r_text_len;
                    n_s1.vert  = i_cfg.read_vertical;
                    n_s1.ovf   = r_ovf;
                    n_s1.bad   = key_bad(i_cfg.key_length, i_cfg.column_order);
                    n_s1.last  = ((LEN_W+1)'(r_out_pos) + (LEN_W+1)'(1))
                                 >= (LEN_W+1)'(r_text_len);
                    if (n_s1.last) begin
                        n_text_len  = '0;
                        n_full_rows = '0;
                        n_load_col  = '0;
                        n_loaded    = 1'b0;
                        n_ovf       = 1'b0;
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_pos   = '0;
                    end else begin
                        n_out_pos = r_out_pos + LEN_W'(1);
                        if (KC_W'(r_out_col) + KC_W'(1) >= kc) begin
                            n_out_col = '0;
                            n_out_row = r_out_row + LEN_W'(1);
                        end else begin
                            n_out_col = r_out_col + COL_W'(1);
                        end
                    end
                end
            end
        end
    end

    // products of the source address and of the body limit
    always_comb begin
        n_s2        = '0;
        n_s2.kind   = r_s1.kind;
        n_s2.waddr  = r_s1.waddr;
        n_s2.data   = r_s1.data;
        n_s2.limit  = PROD_W'(r_s1.rows) * PROD_W'(r_s1.kc);
        n_s2.pos    = r_s1.pos;
        n_s2.len    = r_s1.len;
        n_s2.ovf    = r_s1.ovf;
        n_s2.bad    = r_s1.bad;
        n_s2.last   = r_s1.last;
        if (r_s1.vert) begin
            n_s2.base   = PROD_W'(r_s1.entry) * PROD_W'(r_s1.rows);
            n_s2.offset = r_s1.row;
        end else begin
            n_s2.base   = PROD_W'(r_s1.row) * PROD_W'(r_s1.kc);
            n_s2.offset = LEN_W'(r_s1.entry);
        end
    end

    logic [PROD_W:0] src;

    always_comb begin
        if (PROD_W'(r_s2.pos) < r_s2.limit) begin
            src = (PROD_W+1)'(r_s2.base) + (PROD_W+1)'(r_s2.offset);
        end else begin
            src = (PROD_W+1)'(r_s2.pos);
        end
        o_push       = r_s2_valid;
        o_op.kind    = r_s2.kind;
        o_op.data    = r_s2.data;
        o_op.last    = r_s2.last;
        o_op.ovf     = r_s2.ovf;
        o_op.bad     = r_s2.bad;
        o_op.rd_en   = 1'b0;
        o_op.addr    = r_s2.waddr;
        if (r_s2.kind == OP_FETCH) begin
            o_op.rd_en = !r_s2.bad && (src < (PROD_W+1)'(r_s2.len));
            o_op.addr  = src[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_len  <= '0;
            r_full_rows <= '0;
            r_load_col  <= '0;
            r_loaded    <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_pos   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            r_text_len  <= n_text_len;
            r_full_rows <= n_full_rows;
            r_load_col  <= n_load_col;
            r_loaded    <= n_loaded;
            r_ovf       <= n_ovf;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_pos   <= n_out_pos;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
    end

endmodule

/* rtl/core/ctd_queue.sv */
`timescale 1ns / 1ps

module ctd_queue import ctd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op,
    output logic o_nearly_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    // two beats may still be on their way through the address stages
    assign o_nearly_full = (r_count >= CNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/core/ctd_back.sv */
`timescale 1ns / 1ps

module ctd_back import ctd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_op               i_op,
    output logic              o_pop,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    output logic              o_overflow,
    output logic              o_bad_key
);

    logic              r_pend_valid;
    logic              r_rd_en;
    logic              r_last;
    logic              r_ovf;
    logic              r_bad;
    logic [CHAR_W-1:0] rdata;
    logic              we;

    // the output side never stalls, so the head is taken every cycle
    assign o_pop = i_valid;
    assign we    = i_valid && (i_op.kind == OP_LOAD);

    ctd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (i_op.addr),
        .i_wdata (i_op.data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= i_valid && (i_op.kind == OP_FETCH);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_en <= i_op.rd_en;
        r_last  <= i_op.last;
        r_ovf   <= i_op.ovf;
        r_bad   <= i_op.bad;
    end

    assign o_valid    = r_pend_valid;
    assign o_out_char = r_rd_en ? rdata : '0;
    assign o_out_last = r_last;
    assign o_overflow = r_ovf;
    assign o_bad_key  = r_bad;

endmodule

/* rtl/core/columnar_transposition_decrypt.sv */
`timescale 1ns / 1ps
// a fetch passes the stage-one and stage-two registers, the access queue and the RAM
// read register before its result strobe shows; a load gives no result
// throughput: one beat per cycle, loads and fetches in any mix; busy only rises
// if the access queue backs up, which the never-stalling output side prevents
// reset (synchronous, active low) empties the text, clears the flags and sets K to 1

module columnar_transposition_decrypt import ctd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_req_type,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_in_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_out_last,
    output logic                 o_overflow,
    output logic                 o_bad_key
);

    t_cfg r_cfg;
    logic accept;
    logic push;
    t_op  push_op;
    logic q_valid;
    t_op  q_op;
    logic q_pop;
    logic q_nearly_full;

    assign busy   = q_nearly_full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_length    <= KL_W'(1);
            r_cfg.column_order  <= '0;
            r_cfg.read_vertical <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LENGTH:    r_cfg.key_length    <= i_cfg_data[KL_W-1:0];
                CFG_COLUMN_ORDER:  r_cfg.column_order  <= i_cfg_data[ORDER_W-1:0];
                CFG_READ_VERTICAL: r_cfg.read_vertical <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ctd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_in_char  (i_in_char),
        .i_in_last  (i_in_last),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_op       (push_op)
    );

    ctd_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_op          (push_op),
        .i_pop         (q_pop),
        .o_valid       (q_valid),
        .o_op          (q_op),
        .o_nearly_full (q_nearly_full)
    );

    ctd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_op       (q_op),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last),
        .o_overflow (o_overflow),
        .o_bad_key  (o_bad_key)
    );

endmodule

/* rtl/core/ctd_checker.sv */
`timescale 1ns / 1ps

module ctd_checker import ctd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_req_type,
    input logic              o_valid,
    input logic [CHAR_W-1:0] o_out_char,
    input logic              o_bad_key
);

    // nothing comes out in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // a bad key always yields zero bytes
    a_bad_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_key) |-> (o_out_char == '0))
        else $error("non-zero byte with bad key");

    // every strobe traces back to an accepted fetch beat
    a_strobe_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_req_type, 4))
        else $error("result strobe without a matching fetch");

    // a load beat never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |-> ##4 !o_valid)
        else $error("result strobe caused by a load");

endmodule

bind columnar_transposition_decrypt ctd_checker u_ctd_checker (.*);
